// File: sv/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque package
// Transaction types, operation codes and constants shared by the deque files.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int FUNC_W  = 3;
   localparam int WORD_W  = 32;
   localparam int CAP_W   = 5;
   localparam int COUNT_W = 5;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CAP_RESET     = 16;

   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     accepted;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
      logic [COUNT_W-1:0]       entry_count;
   } rsp_type;

endpackage

// File: sv/cdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// File: sv/circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque
// Bounded double-ended queue of signed words held in a ring RAM.
//
//   Channel   Ports                         Handshake
//   request   start, busy, req_data         start high and busy low
//   response  rsp_valid, rsp_data           one-cycle strobe, no back-pressure
//   config    csr_valid, csr_ready, csr_data  valid and ready both high
//
// A transaction is taken in every cycle and its response appears in the next
// cycle, set by the registered read of the ring RAM.
// Reset is synchronous; no clearing pass is needed.
// busy never rises, and the response side cannot stall.
// ----------------------------------------------------------------------------
module circular_deque #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  cdq_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output cdq_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [cdq_pkg::CAP_W-1:0]    csr_data
);

   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int CAP_INIT = (cdq_pkg::CAP_RESET > DEPTH) ? DEPTH : cdq_pkg::CAP_RESET;

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff;
   logic             ok_ff, ok_in;
   logic             byp_front_ff, byp_front_in;
   logic             byp_back_ff, byp_back_in;
   logic signed [cdq_pkg::WORD_W-1:0] word_ff;

   logic             accept;
   logic             cfg_write;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] front_up, front_down, back_up, back_down;
   logic [cdq_pkg::WORD_W-1:0] rd_front, rd_back;
   logic [31:0]      cap_raw;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign cfg_write = csr_valid && csr_ready;

   always_comb begin
      cap_raw = {{(32 - cdq_pkg::CAP_W){1'b0}}, csr_data};
      if (cap_raw == 32'd0) begin
         cap_raw = 32'd1;
      end
      if (cap_raw > 32'(DEPTH)) begin
         cap_raw = 32'(DEPTH);
      end
      cap_in = CNT_W'(cap_raw);
   end

   assign front_up   = ((CNT_W'(front_ff) + CNT_W'(1)) >= cap_ff) ? '0 : front_ff + IDX_W'(1);
   assign front_down = (front_ff == '0) ? IDX_W'(cap_ff - CNT_W'(1)) : front_ff - IDX_W'(1);
   assign back_up    = ((CNT_W'(back_ff) + CNT_W'(1)) >= cap_ff) ? '0 : back_ff + IDX_W'(1);
   assign back_down  = (back_ff == '0) ? IDX_W'(cap_ff - CNT_W'(1)) : back_ff - IDX_W'(1);

   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      ok_in    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = front_ff;
      if (accept) begin
         case (req_data.func)
            cdq_pkg::FUNC_PUSH_FRONT, cdq_pkg::FUNC_PUSH_BACK: begin
               if (count_ff < cap_ff) begin
                  if (count_ff == '0) begin
                     back_in = front_ff;
                     wr_addr = front_ff;
                  end else if (req_data.func == cdq_pkg::FUNC_PUSH_FRONT) begin
                     front_in = front_down;
                     wr_addr  = front_down;
                  end else begin
                     back_in = back_up;
                     wr_addr = back_up;
                  end
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  ok_in    = 1'b1;
               end
            end
            cdq_pkg::FUNC_POP_FRONT, cdq_pkg::FUNC_POP_BACK: begin
               if (count_ff != '0) begin
                  if (req_data.func == cdq_pkg::FUNC_POP_FRONT) begin
                     front_in = front_up;
                  end else begin
                     back_in = back_down;
                  end
                  count_in = count_ff - CNT_W'(1);
                  ok_in    = 1'b1;
               end
            end
            cdq_pkg::FUNC_QUERY: begin
               ok_in = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
      byp_front_in = wr_en && (wr_addr == front_in);
      byp_back_in  = wr_en && (wr_addr == back_in);
   end

   cdq_ram #(
      .WIDTH(cdq_pkg::WORD_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (req_data.value),
      .rd_addr_a(front_in),
      .rd_data_a(rd_front),
      .rd_addr_b(back_in),
      .rd_data_b(rd_back)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CNT_W'(CAP_INIT);
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cfg_write) begin
         cap_ff       <= cap_in;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      ok_ff        <= ok_in;
      byp_front_ff <= byp_front_in;
      byp_back_ff  <= byp_back_in;
      word_ff      <= req_data.value;
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.accepted    = ok_ff;
      rsp_data.is_empty    = (count_ff == '0);
      rsp_data.is_full     = (count_ff == cap_ff);
      rsp_data.entry_count = cdq_pkg::COUNT_W'(count_ff);
      if (count_ff == '0) begin
         rsp_data.front_value = cdq_pkg::EMPTY_WORD;
         rsp_data.rear_value  = cdq_pkg::EMPTY_WORD;
      end else begin
         rsp_data.front_value = byp_front_ff ? word_ff : $signed(rd_front);
         rsp_data.rear_value  = byp_back_ff ? word_ff : $signed(rd_back);
      end
   end

endmodule

// File: tb/tb_circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque testbench
// Sends push, pop, query and unused operation codes to the deque and
// rewrites the capacity register between phases. Each response is checked
// field by field against a built-in deque model or a directed row's own
// values. A short directed table comes first, then random traffic that
// swings between filling and draining at several capacities and idle rates.
// ----------------------------------------------------------------------------
module tb_circular_deque;

   localparam int DEPTH = cdq_pkg::DEPTH_DEFAULT;
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_UNDEF_A = 3'd5;
   localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_UNDEF_B = 3'd6;
   localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_UNDEF_C = 3'd7;
   localparam int N_ROWS = 27;
   localparam int SEGMENTS = 10;
   localparam int SEG_ITEMS = 50;

   typedef struct packed {
      logic                      is_cfg;
      logic [cdq_pkg::CAP_W-1:0] cap;
      cdq_pkg::req_type          req;
      logic                      typed;
      cdq_pkg::rsp_type          rsp;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   cdq_pkg::req_type          req_data = '0;
   logic                      rsp_valid;
   cdq_pkg::rsp_type          rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [cdq_pkg::CAP_W-1:0] csr_data = '0;

   logic             typed_on = 1'b0;
   cdq_pkg::rsp_type typed_rsp = '0;
   int               sender_idle = 37;
   int               errors = 0;
   cdq_pkg::rsp_type pending [$];
   stim_row_type     directed [N_ROWS];

   int unsigned        cap_now = cdq_pkg::CAP_RESET;
   int unsigned        head = 0;
   int unsigned        tail = 0;
   int unsigned        held = 0;
   logic signed [31:0] ring [DEPTH];

   circular_deque dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned wrap_up(int unsigned p);
      return (p + 1 >= cap_now) ? 0 : p + 1;
   endfunction

   function automatic int unsigned wrap_down(int unsigned p);
      return (p == 0) ? cap_now - 1 : p - 1;
   endfunction

   task automatic step_deque(input cdq_pkg::req_type r, output cdq_pkg::rsp_type o);
      logic ok;
      ok = 1'b0;
      case (r.func)
         cdq_pkg::FUNC_PUSH_FRONT, cdq_pkg::FUNC_PUSH_BACK: begin
            if (held < cap_now) begin
               if (held == 0) begin
                  ring[IDX_W'(head)] = r.value;
                  tail = head;
               end else if (r.func == cdq_pkg::FUNC_PUSH_FRONT) begin
                  head = wrap_down(head);
                  ring[IDX_W'(head)] = r.value;
               end else begin
                  tail = wrap_up(tail);
                  ring[IDX_W'(tail)] = r.value;
               end
               held++;
               ok = 1'b1;
            end
         end
         cdq_pkg::FUNC_POP_FRONT, cdq_pkg::FUNC_POP_BACK: begin
            if (held != 0) begin
               if (r.func == cdq_pkg::FUNC_POP_FRONT) head = wrap_up(head);
               else tail = wrap_down(tail);
               held--;
               ok = 1'b1;
            end
         end
         cdq_pkg::FUNC_QUERY: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      o.accepted    = ok;
      o.front_value = (held == 0) ? cdq_pkg::EMPTY_WORD : ring[IDX_W'(head)];
      o.rear_value  = (held == 0) ? cdq_pkg::EMPTY_WORD : ring[IDX_W'(tail)];
      o.is_empty    = (held == 0);
      o.is_full     = (held == cap_now);
      o.entry_count = cdq_pkg::COUNT_W'(held);
   endtask

   task automatic check_result(input cdq_pkg::rsp_type want, input cdq_pkg::rsp_type got);
      if (got.accepted !== want.accepted) begin
         $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
         errors++;
      end
      if (got.front_value !== want.front_value) begin
         $error("front_value: expected %0d, got %0d", want.front_value, got.front_value);
         errors++;
      end
      if (got.rear_value !== want.rear_value) begin
         $error("rear_value: expected %0d, got %0d", want.rear_value, got.rear_value);
         errors++;
      end
      if (got.is_empty !== want.is_empty) begin
         $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
         errors++;
      end
      if (got.is_full !== want.is_full) begin
         $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
         errors++;
      end
      if (got.entry_count !== want.entry_count) begin
         $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      cdq_pkg::rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_data == 0) cap_now = 1;
            else if (csr_data > DEPTH) cap_now = DEPTH;
            else cap_now = 32'(csr_data);
            head = 0;
            tail = 0;
            held = 0;
         end
         if (start && !busy) begin
            step_deque(req_data, want);
            if (typed_on) want = typed_rsp;
            pending.push_back(want);
         end
         if (rsp_valid) begin
            if (pending.size() == 0) begin
               $error("response transaction with no expectation pending");
               errors++;
            end else begin
               check_result(pending.pop_front(), rsp_data);
            end
         end
      end
   end

   task automatic issue_op(input cdq_pkg::req_type r, input logic typed,
                           input cdq_pkg::rsp_type t);
      while ($urandom_range(99) < sender_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_data  <= r;
      typed_on  <= typed;
      typed_rsp <= t;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_capacity(input logic [cdq_pkg::CAP_W-1:0] c);
      start <= 1'b0;
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= c;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic cdq_pkg::req_type random_op(int push_pct);
      cdq_pkg::req_type r;
      int               roll;
      roll    = $urandom_range(99);
      r.value = $urandom;
      if (roll < 4)
         r.func = cdq_pkg::FUNC_W'($urandom_range(FUNC_UNDEF_A, FUNC_UNDEF_C));
      else if (roll < 12) r.func = cdq_pkg::FUNC_QUERY;
      else if ($urandom_range(99) < push_pct)
         r.func = $urandom_range(1) ? cdq_pkg::FUNC_PUSH_BACK : cdq_pkg::FUNC_PUSH_FRONT;
      else
         r.func = $urandom_range(1) ? cdq_pkg::FUNC_POP_BACK : cdq_pkg::FUNC_POP_FRONT;
      return r;
   endfunction

   initial begin : stimulus
      int i;
      int seg;
      int n;
      logic [cdq_pkg::CAP_W-1:0] cap;
      directed = '{
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_QUERY, 32'sd0}, 1'b1,
           '{1'b1, cdq_pkg::EMPTY_WORD, cdq_pkg::EMPTY_WORD, 1'b1, 1'b0, 5'd0}},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_POP_FRONT, 32'sd0}, 1'b1,
           '{1'b0, cdq_pkg::EMPTY_WORD, cdq_pkg::EMPTY_WORD, 1'b1, 1'b0, 5'd0}},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_POP_BACK, 32'sd0}, 1'b1,
           '{1'b0, cdq_pkg::EMPTY_WORD, cdq_pkg::EMPTY_WORD, 1'b1, 1'b0, 5'd0}},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_PUSH_FRONT, 32'sh7FFFFFFF}, 1'b1,
           '{1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 1'b0, 5'd1}},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_PUSH_BACK, 32'sh80000000}, 1'b1,
           '{1'b1, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, 1'b0, 5'd2}},
         '{1'b0, 5'd0, '{FUNC_UNDEF_A, 32'sd0}, 1'b1,
           '{1'b0, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, 1'b0, 5'd2}},
         '{1'b0, 5'd0, '{FUNC_UNDEF_B, 32'sh12345678}, 1'b1,
           '{1'b0, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, 1'b0, 5'd2}},
         '{1'b0, 5'd0, '{FUNC_UNDEF_C, 32'sh12345678}, 1'b1,
           '{1'b0, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, 1'b0, 5'd2}},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_PUSH_FRONT, 32'sd0}, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_POP_BACK, 32'sd0}, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_POP_FRONT, 32'sd0}, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_POP_FRONT, 32'sd0}, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_QUERY, 32'sd0}, 1'b0, '0},
         '{1'b1, 5'd0, '0, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_PUSH_BACK, -32'sd1}, 1'b1,
           '{1'b1, cdq_pkg::EMPTY_WORD, cdq_pkg::EMPTY_WORD, 1'b0, 1'b1, 5'd1}},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_PUSH_FRONT, 32'sd5}, 1'b1,
           '{1'b0, cdq_pkg::EMPTY_WORD, cdq_pkg::EMPTY_WORD, 1'b0, 1'b1, 5'd1}},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_POP_FRONT, 32'sd0}, 1'b1,
           '{1'b1, cdq_pkg::EMPTY_WORD, cdq_pkg::EMPTY_WORD, 1'b1, 1'b0, 5'd0}},
         '{1'b1, 5'd31, '0, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_PUSH_BACK, 32'sd1}, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_POP_FRONT, 32'sd0}, 1'b0, '0},
         '{1'b1, 5'd2, '0, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_PUSH_FRONT, 32'sh55555555}, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_PUSH_FRONT, 32'shAAAAAAAA}, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_PUSH_BACK, 32'sd3}, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_POP_BACK, 32'sd0}, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_PUSH_BACK, 32'sd4}, 1'b0, '0},
         '{1'b0, 5'd0, '{cdq_pkg::FUNC_QUERY, 32'sd0}, 1'b0, '0}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < N_ROWS; i++) begin
         if (directed[i].is_cfg) write_capacity(directed[i].cap);
         else issue_op(directed[i].req, directed[i].typed, directed[i].rsp);
      end

      for (seg = 0; seg < SEGMENTS; seg++) begin
         sender_idle = (seg < 4) ? 37 : (seg < 7) ? 75 : 0;
         case (seg)
            0:       cap = 5'd16;
            1:       cap = 5'd1;
            2:       cap = 5'd2;
            default: cap = cdq_pkg::CAP_W'($urandom_range(31));
         endcase
         write_capacity(cap);
         for (i = 0; i < SEG_ITEMS; i++)
            issue_op(random_op(((i / 24) % 2 == 0) ? 90 : 20), 1'b0, '0);
      end

      start <= 1'b0;
      @(posedge clock);
      for (n = 0; n < 100 && pending.size() != 0; n++) @(posedge clock);
      repeat (3) @(posedge clock);
      if (pending.size() != 0) begin
         $error("%0d response transactions never arrived", pending.size());
         errors++;
      end
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
